### rtl/i2cm_pkg.sv
// shared types, command codes and sequence lengths for the i2c master bit engine
package i2cm_pkg;

  localparam int DATA_BITS = 8;
  localparam int STEP_W    = 5;
  localparam int SLOT_W    = 16;
  localparam logic [SLOT_W-1:0] SLOT_RESET = 16'd720;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_SACK  = 3'd5,
    CMD_RACK  = 3'd6
  } cmd_e_t;

  typedef struct packed {
    logic [2:0]           cmd;
    logic [DATA_BITS-1:0] tx_byte;
    logic                 ack_out;
    logic                 sda_in;
  } in_t;

  typedef struct packed {
    logic                 scl_drive;
    logic                 sda_drive;
    logic                 busy_res;
    logic                 done_res;
    logic [DATA_BITS-1:0] rx_byte;
    logic                 ack_in;
    logic                 rejected;
  } out_t;

  // number of pin steps in each command sequence
  function automatic logic [STEP_W-1:0] seq_len(input cmd_e_t c);
    logic [STEP_W-1:0] n;
    case (c)
      CMD_START: n = STEP_W'(4);
      CMD_STOP:  n = STEP_W'(3);
      CMD_WRITE: n = STEP_W'(3 * DATA_BITS);
      CMD_READ:  n = STEP_W'(1 + 3 * DATA_BITS);
      CMD_SACK:  n = STEP_W'(3);
      CMD_RACK:  n = STEP_W'(4);
      default:   n = '0;
    endcase
    return n;
  endfunction

endpackage

### rtl/i2cm_seq.sv
// pin step sequencer: engine state and the per-tick update
module i2cm_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  i2cm_pkg::in_t                  item,
  input  logic [i2cm_pkg::SLOT_W-1:0]    slot_cycles,
  output i2cm_pkg::out_t                 res
);
  import i2cm_pkg::*;

  cmd_e_t                active_r, active_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [1:0]            phase_r, phase_nxt;
  logic [SLOT_W-1:0]     slot_cnt_r, slot_cnt_nxt;
  logic [DATA_BITS-1:0]  shift_r, shift_nxt;
  logic [DATA_BITS-1:0]  rxb_r, rxb_nxt;
  logic [1:0]            ack_r, ack_nxt;
  logic                  scl_r, scl_nxt;
  logic                  sda_r, sda_nxt;

  logic                  valid_cmd;
  logic                  go;
  cmd_e_t                cmd_go;
  logic [STEP_W-1:0]     step_go;
  logic [STEP_W-1:0]     step_inc;
  logic [1:0]            ph_go;
  logic                  done;
  logic                  rej;

  always_comb begin
    valid_cmd    = item.cmd inside {[CMD_START:CMD_RACK]};
    active_nxt   = active_r;
    step_nxt     = step_r;
    phase_nxt    = phase_r;
    slot_cnt_nxt = slot_cnt_r;
    shift_nxt    = shift_r;
    rxb_nxt      = rxb_r;
    ack_nxt      = ack_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    done         = 1'b0;
    rej          = 1'b0;
    go           = 1'b0;
    cmd_go       = active_r;
    step_go      = step_r;
    ph_go        = phase_r;
    step_inc     = STEP_W'(step_r + 1'b1);

    if (active_r != CMD_NONE) begin
      rej = valid_cmd;
      if (slot_cnt_r >= slot_cycles) begin
        if (step_inc >= seq_len(active_r)) begin
          if (active_r == CMD_READ) begin
            rxb_nxt = shift_r;
          end
          active_nxt   = CMD_NONE;
          step_nxt     = '0;
          phase_nxt    = '0;
          slot_cnt_nxt = '0;
          done         = 1'b1;
        end else begin
          go      = 1'b1;
          step_go = step_inc;
          // read phases count from the step after the release of sda
          if (active_r == CMD_READ && step_r == '0) begin
            ph_go = 2'd0;
          end else begin
            ph_go = (phase_r == 2'd2) ? 2'd0 : phase_r + 2'd1;
          end
          step_nxt     = step_go;
          phase_nxt    = ph_go;
          slot_cnt_nxt = SLOT_W'(1);
        end
      end else begin
        slot_cnt_nxt = slot_cnt_r + 1'b1;
      end
    end else if (valid_cmd) begin
      cmd_go       = cmd_e_t'(item.cmd);
      active_nxt   = cmd_go;
      step_go      = '0;
      ph_go        = 2'd0;
      step_nxt     = '0;
      phase_nxt    = 2'd0;
      slot_cnt_nxt = SLOT_W'(1);
      go           = 1'b1;
      if (cmd_go == CMD_WRITE) begin
        shift_nxt = item.tx_byte;
      end
      if (cmd_go == CMD_SACK) begin
        ack_nxt[0] = item.ack_out;
      end
    end

    if (go) begin
      case (cmd_go)
        CMD_START: begin
          case (step_go[1:0])
            2'd0:    sda_nxt = 1'b1;
            2'd1:    scl_nxt = 1'b1;
            2'd2:    sda_nxt = 1'b0;
            default: scl_nxt = 1'b0;
          endcase
        end
        CMD_STOP: begin
          if (step_go == '0) begin
            sda_nxt = 1'b0;
          end else if (step_go == STEP_W'(1)) begin
            scl_nxt = 1'b1;
          end else begin
            sda_nxt = 1'b1;
          end
        end
        CMD_WRITE: begin
          case (ph_go)
            2'd0: begin
              sda_nxt   = shift_nxt[DATA_BITS-1];
              shift_nxt = {shift_nxt[DATA_BITS-2:0], 1'b0};
            end
            2'd1:    scl_nxt = 1'b1;
            default: scl_nxt = 1'b0;
          endcase
        end
        CMD_READ: begin
          if (step_go == '0) begin
            sda_nxt   = 1'b1;
            shift_nxt = '0;
          end else begin
            case (ph_go)
              2'd0:    scl_nxt = 1'b1;
              2'd1:    shift_nxt = {shift_nxt[DATA_BITS-2:0], item.sda_in};
              default: scl_nxt = 1'b0;
            endcase
          end
        end
        CMD_SACK: begin
          if (step_go == '0) begin
            sda_nxt = ack_nxt[0];
          end else if (step_go == STEP_W'(1)) begin
            scl_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b0;
          end
        end
        CMD_RACK: begin
          case (step_go[1:0])
            2'd0:    sda_nxt = 1'b1;
            2'd1:    scl_nxt = 1'b1;
            2'd2:    ack_nxt[1] = item.sda_in;
            default: scl_nxt = 1'b0;
          endcase
        end
        default: ;
      endcase
    end

    res.scl_drive = scl_nxt;
    res.sda_drive = sda_nxt;
    res.busy_res  = (active_nxt != CMD_NONE);
    res.done_res  = done;
    res.rx_byte   = rxb_nxt;
    res.ack_in    = ack_nxt[1];
    res.rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= CMD_NONE;
      step_r     <= '0;
      phase_r    <= '0;
      slot_cnt_r <= '0;
      shift_r    <= '0;
      rxb_r      <= '0;
      ack_r      <= '0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
    end else if (adv) begin
      active_r   <= active_nxt;
      step_r     <= step_nxt;
      phase_r    <= phase_nxt;
      slot_cnt_r <= slot_cnt_nxt;
      shift_r    <= shift_nxt;
      rxb_r      <= rxb_nxt;
      ack_r      <= ack_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
    end
  end

endmodule

### rtl/i2c_master_bit_engine_top.sv
// top level of the i2c master bit engine: input register, sequencer, result register
//
// usage
//   each transfer on the input channel is one tick of the bit engine; it may carry a
//   command (start, stop, write byte, read byte, send ack, receive ack) and always
//   carries the sampled sda level. every input transfer yields exactly one result
//   transfer with the scl/sda drive levels, busy, done, rx byte, ack in and rejected.
//   cfg_we writes slot_cycles (ticks per pin step, reset 720); write it
//   only while the pipeline is empty; a new length applies at once, even mid-step.
// pipeline
//   a tick is held in the input register, then the sequencer updates
//   its state and the result register loads its result.
//   one tick per cycle sustained while out_stall stays low.
// reset
//   synchronous active-low rst_n empties both registers, releases scl and sda,
//   returns the engine to idle and restores slot_cycles to 720.
// stall
//   while out_stall holds a full result register, the input register keeps its tick
//   and in_stall rises; the engine state only advances when the result register has room.
module i2c_master_bit_engine_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  i2cm_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output i2cm_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [i2cm_pkg::SLOT_W-1:0]    cfg_wdata
);
  import i2cm_pkg::*;

  logic [SLOT_W-1:0] slot_cycles_r;
  logic              s1_valid_r;
  in_t               s1_data_r;
  logic              out_valid_r;
  out_t              out_data_r;
  out_t              res;
  logic              adv;

  // the held tick moves on when the result register is empty or draining
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;

  // slot length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_cycles_r <= SLOT_RESET;
    end else if (cfg_we) begin
      slot_cycles_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  // engine state and step logic
  i2cm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .item        (s1_data_r),
    .slot_cycles (slot_cycles_r),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a finishing tick always leaves the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> !out_data_r.busy_res)
    else $error("done reported while still busy");

  // a rejected command can only come while a sequence runs or finishes
  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.rejected |-> out_data_r.busy_res || out_data_r.done_res)
    else $error("command rejected while idle");

  // the input side only stalls with a tick held
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  // a stalled result is not overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !adv)
    else $error("result register overwritten under stall");

endmodule

### sim/tb_top.sv
// self-checking testbench for the i2c master bit engine: tick-level pin predictor and scoreboard
`timescale 1ns / 100ps

module tb_top;
  import i2cm_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 9;
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam int MAX_REPORTS = 10;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_TICKS = 240;
  localparam int BATCH_TICKS = 60;
  // cmd value outside the defined set, must be treated as no command
  localparam logic [2:0] CMD_UNDEF = 3'd7;

  // sda level patterns a command can see on its ticks
  localparam int SDA_LOW = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [SLOT_W-1:0] cfg_wdata = '0;

  always #HALF_PERIOD clk = ~clk;

  i2c_master_bit_engine_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // engine predictor: its own copy of the slot length and the sequencer state
  // ---------------------------------------------------------------------------
  logic [SLOT_W-1:0] m_slot = SLOT_RESET;
  logic              m_scl = 1'b1;
  logic              m_sda = 1'b1;
  cmd_e_t            m_cmd = CMD_NONE;
  logic [4:0]        m_step = '0;
  logic [SLOT_W-1:0] m_cnt = '0;
  logic [7:0]        m_shift = '0;
  logic [7:0]        m_rx = '0;
  logic              m_ack_o = 1'b0;  // bit latched by send ack
  logic              m_ack_i = 1'b0;  // bit sampled by receive ack

  // number of pin steps per command
  function automatic int steps_of(cmd_e_t c);
    case (c)
      CMD_START: return 4;
      CMD_STOP:  return 3;
      CMD_WRITE: return 3 * DATA_BITS;
      CMD_READ:  return 1 + 3 * DATA_BITS;
      CMD_SACK:  return 3;
      CMD_RACK:  return 4;
      default:   return 0;
    endcase
  endfunction

  // apply the pin step m_step of the running command
  function automatic void pin_step(logic sda_now);
    int s;
    s = int'(m_step);
    case (m_cmd)
      CMD_START: begin
        if (s == 0) m_sda = 1'b1;
        else if (s == 1) m_scl = 1'b1;
        else if (s == 2) m_sda = 1'b0;
        else m_scl = 1'b0;
      end
      CMD_STOP: begin
        if (s == 0) m_sda = 1'b0;
        else if (s == 1) m_scl = 1'b1;
        else m_sda = 1'b1;
      end
      CMD_WRITE: begin
        // data, clock high, clock low per bit, msb first
        if (s % 3 == 0) begin
          m_sda = m_shift[7];
          m_shift = {m_shift[6:0], 1'b0};
        end else if (s % 3 == 1) begin
          m_scl = 1'b1;
        end else begin
          m_scl = 1'b0;
        end
      end
      CMD_READ: begin
        // release sda first, then clock high, sample, clock low per bit
        if (s == 0) begin
          m_sda = 1'b1;
          m_shift = '0;
        end else if ((s - 1) % 3 == 0) begin
          m_scl = 1'b1;
        end else if ((s - 1) % 3 == 1) begin
          m_shift = {m_shift[6:0], sda_now};
        end else begin
          m_scl = 1'b0;
        end
      end
      CMD_SACK: begin
        if (s == 0) m_sda = m_ack_o;
        else if (s == 1) m_scl = 1'b1;
        else m_scl = 1'b0;
      end
      CMD_RACK: begin
        if (s == 0) m_sda = 1'b1;
        else if (s == 1) m_scl = 1'b1;
        else if (s == 2) m_ack_i = sda_now;
        else m_scl = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // one engine tick: advance the predicted state and build the expected result
  function automatic out_t predict_pins(in_t t);
    out_t r;
    logic is_cmd;
    logic done;
    logic rej;
    is_cmd = (t.cmd != CMD_NONE) && (t.cmd <= CMD_RACK);
    done = 1'b0;
    rej = 1'b0;
    if (m_cmd != CMD_NONE) begin
      // busy: any real command is dropped, including on the finishing tick
      rej = is_cmd;
      if (m_cnt >= m_slot) begin
        m_step = m_step + 5'd1;
        if (int'(m_step) >= steps_of(m_cmd)) begin
          if (m_cmd == CMD_READ) m_rx = m_shift;
          m_cmd = CMD_NONE;
          m_step = '0;
          m_cnt = '0;
          done = 1'b1;
        end else begin
          pin_step(t.sda_in);
          m_cnt = SLOT_W'(1);
        end
      end else begin
        m_cnt = m_cnt + 1'b1;
      end
    end else if (is_cmd) begin
      // first step acts on the accepting tick
      m_cmd = cmd_e_t'(t.cmd);
      m_step = '0;
      m_cnt = SLOT_W'(1);
      if (m_cmd == CMD_WRITE) m_shift = t.tx_byte;
      if (m_cmd == CMD_SACK) m_ack_o = t.ack_out;
      pin_step(t.sda_in);
    end
    r.scl_drive = m_scl;
    r.sda_drive = m_sda;
    r.busy_res  = (m_cmd != CMD_NONE);
    r.done_res  = done;
    r.rx_byte   = m_rx;
    r.ack_in    = m_ack_i;
    r.rejected  = rej;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // shared testbench state
  // ---------------------------------------------------------------------------
  in_t    ticks_to_send[$];   // filled by the stimulus block, drained by the driver
  out_t   pins_due[$];        // predicted results in transfer order
  bit     on_wire = 1'b0;     // an item sits on in_data waiting for its transfer
  bit     took = 1'b0;        // input transfer at the last rising edge
  int     idle_pct_in = 0;
  int     stall_pct_out = 0;
  int     hold_req = 0;
  int     hold_left = 0;
  longint cycles = 0;
  int     bad_results = 0;
  int     results_seen = 0;
  int     ticks_made = 0;
  logic [SLOT_W-1:0] gen_slot = SLOT_RESET;  // slot length the stimulus plans with

  // ---------------------------------------------------------------------------
  // rising edge: timeout, model reset, config tracking, result check, prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_t want;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else if (!rst_n) begin
      m_slot  = SLOT_RESET;
      m_scl   = 1'b1;
      m_sda   = 1'b1;
      m_cmd   = CMD_NONE;
      m_step  = '0;
      m_cnt   = '0;
      m_shift = '0;
      m_rx    = '0;
      m_ack_o = 1'b0;
      m_ack_i = 1'b0;
      took    = 1'b0;
    end else begin
      took = in_valid && !in_stall;
      // slot write lands at this edge, before any tick that follows it
      if (cfg_we) m_slot = cfg_wdata;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pins_due.size() == 0) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS)
            $display("result %0d: transfer with no prediction pending, data %h",
                     results_seen, out_data);
        end else begin
          want = pins_due.pop_front();
          if (out_data.scl_drive !== want.scl_drive || out_data.sda_drive !== want.sda_drive ||
              out_data.busy_res !== want.busy_res || out_data.done_res !== want.done_res ||
              out_data.rx_byte !== want.rx_byte || out_data.ack_in !== want.ack_in ||
              out_data.rejected !== want.rejected) begin
            bad_results++;
            if (bad_results <= MAX_REPORTS) begin
              $write("result %0d mismatch (expected/actual): scl %b/%b sda %b/%b ",
                     results_seen, want.scl_drive, out_data.scl_drive,
                     want.sda_drive, out_data.sda_drive);
              $display("busy %b/%b done %b/%b rx %h/%h ack %b/%b rej %b/%b",
                       want.busy_res, out_data.busy_res,
                       want.done_res, out_data.done_res, want.rx_byte, out_data.rx_byte,
                       want.ack_in, out_data.ack_in, want.rejected, out_data.rejected);
            end
          end
        end
      end
      if (took) pins_due.push_back(predict_pins(in_data));
    end
  end

  // ---------------------------------------------------------------------------
  // driver: offers the next tick at the falling edge, holds it until the transfer
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || took)) begin
      if (ticks_to_send.size() > 0 && $urandom_range(0, 99) >= idle_pct_in) begin
        in_data <= ticks_to_send.pop_front();
        in_valid <= 1'b1;
        on_wire = 1'b1;
      end else begin
        in_valid <= 1'b0;
        on_wire = 1'b0;
      end
    end
  end

  // receiver: random stall, or a long hold-off counted here when requested
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct_out);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_tick(logic [2:0] c, logic [7:0] tx, logic ack, logic sda);
    in_t t;
    t.cmd = c;
    t.tx_byte = tx;
    t.ack_out = ack;
    t.sda_in = sda;
    ticks_to_send.push_back(t);
    ticks_made++;
  endtask

  // a command plus the ticks it runs for, so the next command lands right after done;
  // noisy adds commands while busy, at_end puts one on the finishing tick
  task automatic issue(cmd_e_t c, logic [7:0] tx, logic ack, int sda_mode, bit noisy,
                       bit at_end);
    int span;
    logic [2:0] k_cmd;
    logic lvl;
    span = steps_of(c) * ((gen_slot == 0) ? 1 : int'(gen_slot));
    for (int k = 0; k <= span; k++) begin
      if (k == 0) k_cmd = c;
      else if (k == span && at_end) k_cmd = 3'($urandom_range(CMD_START, CMD_RACK));
      else if (noisy && $urandom_range(0, 7) == 0)
        k_cmd = 3'($urandom_range(CMD_START, CMD_UNDEF));
      else k_cmd = CMD_NONE;
      if (sda_mode == SDA_RAND) lvl = 1'($urandom_range(0, 1));
      else lvl = (sda_mode == SDA_HIGH);
      if (k == 0) push_tick(k_cmd, tx, ack, lvl);
      else push_tick(k_cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), lvl);
    end
  endtask

  // sender pauses until every predicted result is out; the engine may still be busy
  task automatic drain();
    while (ticks_to_send.size() != 0 || on_wire || pins_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // sender pauses until every predicted result is out and the engine is idle
  task automatic quiesce();
    do begin
      while (ticks_to_send.size() != 0 || on_wire || pins_due.size() != 0) @(negedge clk);
      if (m_cmd != CMD_NONE)
        for (int k = 0; k < 8; k++) push_tick(CMD_NONE, '0, 1'b0, 1'($urandom_range(0, 1)));
    end while (m_cmd != CMD_NONE);
    // both registers are empty once the last result is out; the wait below adds margin
    repeat (4) @(negedge clk);
  endtask

  task automatic write_slot(logic [SLOT_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    gen_slot = v;
  endtask

  initial begin
    int batch;
    int goal;
    int stop_at;
    int sda_mode;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // slot length left at its reset value: run past the first step boundary, then
    // shorten the slot in the middle of the running start, which applies at once
    push_tick(CMD_START, 8'h00, 1'b0, 1'b1);
    repeat (int'(SLOT_RESET) + 1) push_tick(CMD_NONE, 8'h00, 1'b0, 1'b1);
    drain();
    write_slot(16'd1);
    quiesce();

    // directed: every command, extreme bytes, both sda and ack levels
    write_slot(16'd1);
    issue(CMD_START, 8'h00, 1'b0, SDA_RAND, 1'b0, 1'b0);
    issue(CMD_WRITE, 8'h00, 1'b0, SDA_LOW, 1'b0, 1'b0);
    issue(CMD_WRITE, 8'hFF, 1'b1, SDA_HIGH, 1'b0, 1'b0);
    // commands arriving while busy get rejected
    issue(CMD_WRITE, 8'hA5, 1'b0, SDA_RAND, 1'b1, 1'b0);
    issue(CMD_RACK, 8'h00, 1'b1, SDA_LOW, 1'b0, 1'b0);
    // a command on the finishing tick is rejected too
    issue(CMD_RACK, 8'hFF, 1'b0, SDA_HIGH, 1'b0, 1'b1);
    issue(CMD_READ, 8'h00, 1'b0, SDA_HIGH, 1'b0, 1'b0);
    issue(CMD_READ, 8'hFF, 1'b1, SDA_LOW, 1'b0, 1'b0);
    issue(CMD_READ, 8'h3C, 1'b0, SDA_RAND, 1'b1, 1'b1);
    issue(CMD_SACK, 8'h00, 1'b0, SDA_RAND, 1'b0, 1'b0);
    issue(CMD_SACK, 8'hFF, 1'b1, SDA_RAND, 1'b0, 1'b0);
    // undefined command while idle is neither taken nor rejected
    push_tick(CMD_UNDEF, 8'h5A, 1'b1, 1'b1);
    push_tick(CMD_UNDEF, 8'hA5, 1'b0, 1'b0);
    issue(CMD_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0, 1'b0);
    quiesce();

    // zero slot length runs like one
    write_slot(16'd0);
    issue(CMD_START, 8'h00, 1'b0, SDA_RAND, 1'b0, 1'b0);
    issue(CMD_WRITE, 8'h96, 1'b0, SDA_RAND, 1'b1, 1'b0);
    issue(CMD_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0, 1'b1);
    quiesce();

    // random: command streams with random content, short slots, rotating idle mix
    batch = 0;
    goal = ticks_made + RANDOM_TICKS;
    while (ticks_made < goal) begin
      case ($urandom_range(0, 5))
        0:       write_slot(16'd0);
        1, 2:    write_slot(16'd1);
        3:       write_slot(16'd2);
        4:       write_slot(16'd3);
        default: write_slot(SLOT_W'($urandom_range(4, 9)));
      endcase
      case (batch % 4)
        0:       begin idle_pct_in = 0;  stall_pct_out = 0;  end
        1:       begin idle_pct_in = 46; stall_pct_out = 0;  end
        2:       begin idle_pct_in = 0;  stall_pct_out = 46; end
        default: begin idle_pct_in = 11; stall_pct_out = 11; end
      endcase
      // long receiver hold-off while the sender keeps offering, fills the block
      if (batch == 0 || batch == 5) hold_req = LONG_HOLD;
      stop_at = ticks_made + BATCH_TICKS;
      while (ticks_made < stop_at) begin
        if ($urandom_range(0, 3) == 0) sda_mode = $urandom_range(SDA_LOW, SDA_HIGH);
        else sda_mode = SDA_RAND;
        issue(cmd_e_t'($urandom_range(CMD_START, CMD_RACK)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), sda_mode, $urandom_range(0, 2) == 0,
              $urandom_range(0, 4) == 0);
        // occasional idle gap, with or without the undefined code
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 1) == 0)
              push_tick(CMD_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
            else
              push_tick(CMD_UNDEF, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
          end
      end
      quiesce();
      batch++;
    end

    // margin for any stray result after the last expected one
    repeat (8) @(negedge clk);
    if (bad_results == 0 && pins_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
